// ===== rtl/link_handshake_heartbeat_fsm_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the link handshake / heartbeat core
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LINK_HANDSHAKE_HEARTBEAT_FSM_CORE_ASSERT_SVH
`define LINK_HANDSHAKE_HEARTBEAT_FSM_CORE_ASSERT_SVH

// same-cycle implication
`define LHB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("lhb assertion failed");

// next-cycle implication
`define LHB_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("lhb assertion failed");

`endif

// ===== rtl/lhb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhb_pkg
// Types and constants shared by the link handshake / heartbeat core.
// ----------------------------------------------------------------------------
package lhb_pkg;

    localparam int LHB_MAX_RES = 3;

    typedef enum logic [1:0] {
        ST_DISC = 2'd0,
        ST_HAND = 2'd1,
        ST_CONN = 2'd2
    } t_link_state;

    // item kinds
    localparam logic OP_UPDATE   = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    // result kinds
    localparam logic [1:0] RK_STATUS  = 2'd0;
    localparam logic [1:0] RK_SEND    = 2'd1;
    localparam logic [1:0] RK_DELIVER = 2'd2;

    // send kinds
    localparam logic [1:0] SK_HANDSHAKE = 2'd0;
    localparam logic [1:0] SK_HEARTBEAT = 2'd1;
    localparam logic [1:0] SK_NAME      = 2'd2;
    localparam logic [1:0] SK_PONG      = 2'd3;

    // error codes
    localparam logic [1:0] ERR_OK          = 2'd0;
    localparam logic [1:0] ERR_NO_RESPONSE = 2'd1;
    localparam logic [1:0] ERR_HB_TIMEOUT  = 2'd2;

    // datagram opcodes and class
    localparam logic [7:0] OPC_HANDSHAKE_REPLY = 8'd2;
    localparam logic [7:0] OPC_HEARTBEAT       = 8'd3;
    localparam logic [7:0] OPC_PING            = 8'd4;
    localparam logic [7:0] CLASS_MASK          = 8'hF0;
    localparam logic [7:0] NETWORK_CLASS       = 8'h00;
    localparam logic [7:0] MIN_HEADER_LEN      = 8'd8;

    // configuration register indexes
    localparam logic [2:0] CFG_RESPONSE_TIMEOUT   = 3'd0;
    localparam logic [2:0] CFG_RETRY_LIMIT        = 3'd1;
    localparam logic [2:0] CFG_HEARTBEAT_INTERVAL = 3'd2;
    localparam logic [2:0] CFG_HEARTBEAT_TIMEOUT  = 3'd3;
    localparam logic [2:0] CFG_OPENER_VALUE       = 3'd4;

    // configuration reset values
    localparam logic [31:0] RST_RESPONSE_TIMEOUT   = 32'd1000;
    localparam logic [7:0]  RST_RETRY_LIMIT        = 8'd5;
    localparam logic [31:0] RST_HEARTBEAT_INTERVAL = 32'd1000;
    localparam logic [31:0] RST_HEARTBEAT_TIMEOUT  = 32'd5000;
    localparam logic [7:0]  RST_OPENER_VALUE       = 8'd0;

    typedef struct packed {
        logic        opcode;
        logic [31:0] now;
        logic        link_up;
        logic        rx_valid;
        logic [7:0]  rx_length;
        logic [7:0]  rx_header;
        logic [7:0]  rx_opcode;
        logic [31:0] rx_sequence;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [1:0]  send_kind;
        logic [31:0] send_sequence;
        logic [7:0]  deliver_opcode;
        logic [1:0]  error_code;
        logic        connected;
        logic        last;
    } t_out_word;

    typedef struct packed {
        logic [31:0] response_timeout;
        logic [7:0]  retry_limit;
        logic [31:0] heartbeat_interval;
        logic [31:0] heartbeat_timeout;
        logic [7:0]  opener_value;
    } t_lhb_cfg;

    typedef struct packed {
        t_link_state link_state;
        logic [7:0]  retries_done;
        logic [31:0] last_rx_seq;
        logic [31:0] next_tx_seq;
        logic [31:0] handshake_sent_time;
        logic [31:0] heartbeat_sent_time;
        logic [31:0] heartbeat_recv_time;
    } t_lhb_state;

endpackage

// ===== rtl/link_handshake_heartbeat_fsm_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_handshake_heartbeat_fsm_core
// Client link state machine: handshake with retries, heartbeats, dispatch.
// ----------------------------------------------------------------------------
// An input word is taken into an input register and handled in one pass as
// soon as the three-entry result buffer is empty or giving up its last word;
// the first result appears the cycle after that. Each item yields one to three
// result words, and the result buffer hands out one word per cycle while the
// output is not stalled; items with a single status word then flow at one per
// cycle. Configuration writes land at the next clock edge.
module link_handshake_heartbeat_fsm_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lhb_pkg::t_in_word   i_in_word,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lhb_pkg::t_out_word  o_out_word,
    // configuration
    input  logic                i_cfg_wr_en,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_wdata
);
    import lhb_pkg::*;

    t_lhb_cfg                     r_cfg;
    t_lhb_state                   r_state;
    t_lhb_state                   n_state;
    t_in_word                     r_in;
    logic                         r_in_valid;
    t_out_word [LHB_MAX_RES-1:0]  r_buf;
    t_out_word [LHB_MAX_RES-1:0]  n_res;
    logic [1:0]                   r_cnt;
    logic [1:0]                   n_cnt;
    logic                         in_take;
    logic                         out_take;
    logic                         process;

    lhb_step u_step (
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .i_word  (r_in),
        .o_state (n_state),
        .o_res   (n_res),
        .o_cnt   (n_cnt)
    );

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_word  = r_buf[0];
    assign out_take    = o_out_valid && !i_out_stall;
    assign process     = r_in_valid &&
                         ((r_cnt == 2'd0) || ((r_cnt == 2'd1) && out_take));
    assign o_in_stall  = r_in_valid && !process;
    assign in_take     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.response_timeout   <= RST_RESPONSE_TIMEOUT;
            r_cfg.retry_limit        <= RST_RETRY_LIMIT;
            r_cfg.heartbeat_interval <= RST_HEARTBEAT_INTERVAL;
            r_cfg.heartbeat_timeout  <= RST_HEARTBEAT_TIMEOUT;
            r_cfg.opener_value       <= RST_OPENER_VALUE;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_RESPONSE_TIMEOUT:   r_cfg.response_timeout   <= i_cfg_wdata;
                CFG_RETRY_LIMIT:        r_cfg.retry_limit        <= i_cfg_wdata[7:0];
                CFG_HEARTBEAT_INTERVAL: r_cfg.heartbeat_interval <= i_cfg_wdata;
                CFG_HEARTBEAT_TIMEOUT:  r_cfg.heartbeat_timeout  <= i_cfg_wdata;
                CFG_OPENER_VALUE:       r_cfg.opener_value       <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.link_state          <= ST_DISC;
            r_state.retries_done        <= '0;
            r_state.last_rx_seq         <= '0;
            r_state.next_tx_seq         <= '0;
            r_state.handshake_sent_time <= '0;
            r_state.heartbeat_sent_time <= '0;
            r_state.heartbeat_recv_time <= '0;
            r_in_valid                  <= 1'b0;
            r_cnt                       <= 2'd0;
        end else begin
            if (process) begin
                r_state <= n_state;
                r_cnt   <= n_cnt;
            end else if (out_take) begin
                r_cnt <= r_cnt - 2'd1;
            end
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (process) begin
                r_in_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_word;
        end
        if (process) begin
            r_buf <= n_res;
        end else if (out_take) begin
            r_buf[0] <= r_buf[1];
            r_buf[1] <= r_buf[2];
        end
    end

endmodule

// ===== rtl/lhb_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhb_step
// Combinational next-state and result builder for one input word.
// ----------------------------------------------------------------------------
module lhb_step (
    input  lhb_pkg::t_lhb_state                       i_state,
    input  lhb_pkg::t_lhb_cfg                         i_cfg,
    input  lhb_pkg::t_in_word                         i_word,
    output lhb_pkg::t_lhb_state                       o_state,
    output lhb_pkg::t_out_word [lhb_pkg::LHB_MAX_RES-1:0] o_res,
    output logic [1:0]                                o_cnt
);
    import lhb_pkg::*;

    logic [31:0] hs_due;
    logic [31:0] hb_tx_due;
    logic [31:0] hb_rx_due;
    logic        hs_expired;
    logic        hb_tx_expired;
    logic        hb_rx_expired;
    logic        reply_ok;

    // wrap-around sums, unsigned compare
    assign hs_due        = i_state.handshake_sent_time + i_cfg.response_timeout;
    assign hb_tx_due     = i_state.heartbeat_sent_time + i_cfg.heartbeat_interval;
    assign hb_rx_due     = i_state.heartbeat_recv_time + i_cfg.heartbeat_timeout;
    assign hs_expired    = i_word.now > hs_due;
    assign hb_tx_expired = i_word.now > hb_tx_due;
    assign hb_rx_expired = i_word.now > hb_rx_due;

    assign reply_ok = i_word.rx_valid && (i_word.rx_length >= MIN_HEADER_LEN) &&
                      (i_word.rx_header == i_cfg.opener_value) &&
                      (i_word.rx_sequence > i_state.last_rx_seq);

    always_comb begin
        t_lhb_state                    st;
        t_out_word [LHB_MAX_RES-1:0]   res;
        logic [1:0]                    cnt;
        logic [1:0]                    err;
        logic                          snd;
        logic [1:0]                    snd_kind;
        logic                          snd2;

        st       = i_state;
        res      = '0;
        cnt      = 2'd0;
        err      = ERR_OK;
        snd      = 1'b0;
        snd_kind = SK_HANDSHAKE;
        snd2     = 1'b0;

        if (i_word.opcode == OP_UPDATE) begin
            case (i_state.link_state)
                ST_HAND: begin
                    if (hs_expired) begin
                        if (i_state.retries_done < i_cfg.retry_limit) begin
                            st.retries_done        = i_state.retries_done + 8'd1;
                            st.handshake_sent_time = i_word.now;
                            snd                    = 1'b1;
                            snd_kind               = SK_HANDSHAKE;
                        end else begin
                            st.link_state = ST_DISC;
                            err           = ERR_NO_RESPONSE;
                        end
                    end else if (reply_ok) begin
                        st.last_rx_seq = i_word.rx_sequence;
                        if (i_word.rx_opcode == OPC_HANDSHAKE_REPLY) begin
                            st.link_state          = ST_CONN;
                            st.heartbeat_sent_time = i_word.now;
                            st.heartbeat_recv_time = i_word.now;
                            snd                    = 1'b1;
                            snd_kind               = SK_HEARTBEAT;
                            snd2                   = 1'b1;
                        end
                    end
                end
                ST_CONN: begin
                    if (hb_tx_expired) begin
                        st.heartbeat_sent_time = i_word.now;
                        snd                    = 1'b1;
                        snd_kind               = SK_HEARTBEAT;
                    end
                end
                default: begin
                    st.link_state = ST_DISC;
                    if (i_word.link_up) begin
                        st.retries_done        = 8'd1;
                        st.link_state          = ST_HAND;
                        st.handshake_sent_time = i_word.now;
                        snd                    = 1'b1;
                        snd_kind               = SK_HANDSHAKE;
                    end
                end
            endcase
        end else if (i_word.rx_valid) begin
            if ((i_word.rx_opcode & CLASS_MASK) == NETWORK_CLASS) begin
                if (i_word.rx_opcode == OPC_HEARTBEAT) begin
                    st.heartbeat_recv_time = i_word.now;
                end else if (i_word.rx_opcode == OPC_PING) begin
                    snd      = 1'b1;
                    snd_kind = SK_PONG;
                end
            end else begin
                res[0].result_kind    = RK_DELIVER;
                res[0].deliver_opcode = i_word.rx_opcode;
                cnt                   = 2'd1;
            end
        end

        if (snd) begin
            res[0].result_kind   = RK_SEND;
            res[0].send_kind     = snd_kind;
            res[0].send_sequence = i_state.next_tx_seq;
            cnt                  = 2'd1;
            st.next_tx_seq       = i_state.next_tx_seq + 32'd1;
        end
        // client name follows the first heartbeat after a good reply
        if (snd2) begin
            res[1].result_kind   = RK_SEND;
            res[1].send_kind     = SK_NAME;
            res[1].send_sequence = i_state.next_tx_seq + 32'd1;
            cnt                  = 2'd2;
            st.next_tx_seq       = i_state.next_tx_seq + 32'd2;
        end

        // receive watchdog: the heartbeat above is still reported
        if ((i_word.opcode == OP_UPDATE) && (i_state.link_state == ST_CONN) &&
            hb_rx_expired) begin
            st.last_rx_seq         = '0;
            st.next_tx_seq         = '0;
            st.handshake_sent_time = '0;
            st.heartbeat_sent_time = '0;
            st.heartbeat_recv_time = '0;
            st.link_state          = ST_DISC;
            err                    = ERR_HB_TIMEOUT;
        end

        res[cnt].result_kind = RK_STATUS;
        res[cnt].error_code  = err;
        res[cnt].last        = 1'b1;
        for (int k = 0; k < LHB_MAX_RES; k++) begin
            res[k].connected = (st.link_state == ST_CONN);
        end

        o_state = st;
        o_res   = res;
        o_cnt   = cnt + 2'd1;
    end

endmodule

// ===== rtl/lhb_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhb_chk
// Port-level checks on the result channel of the link core.
// ----------------------------------------------------------------------------
`include "link_handshake_heartbeat_fsm_core_assert.svh"

module lhb_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input lhb_pkg::t_out_word o_out_word
);
    import lhb_pkg::*;

    // stalled result word holds
    `LHB_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_word))
    // the closing word of an item is always its status
    `LHB_ASSERT_NOW(a_last_is_status, o_out_valid && o_out_word.last, o_out_word.result_kind == RK_STATUS)
    // and every status word closes its item
    `LHB_ASSERT_NOW(a_status_is_last, o_out_valid && (o_out_word.result_kind == RK_STATUS), o_out_word.last)
    // an error always leaves the link down
    `LHB_ASSERT_NOW(a_err_disc, o_out_valid && (o_out_word.error_code != ERR_OK), !o_out_word.connected)

endmodule

bind link_handshake_heartbeat_fsm_core lhb_chk u_lhb_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
